/* design/pulsed_turn_drive_controller_defines.svh */
// ----------------------------------------------------------------------------
// Pulsed turn drive controller assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PULSED_TURN_DRIVE_CONTROLLER_DEFINES_SVH
`define PULSED_TURN_DRIVE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define PTDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/ptdc_pkg.sv */
// ----------------------------------------------------------------------------
// ptdc_pkg
// Types, codes and helpers of the pulsed turn drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ptdc_pkg;

    localparam int NumWheels = 4;

    typedef logic [1:0] t_dir;
    localparam t_dir DirZero = 2'b00;
    localparam t_dir DirPos  = 2'b01;
    localparam t_dir DirNeg  = 2'b11;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CfgPeriod = 3'd0;
    localparam t_cfg_idx CfgDrive  = 3'd1;
    localparam t_cfg_idx CfgCoast  = 3'd2;
    localparam t_cfg_idx CfgLevel  = 3'd3;
    localparam t_cfg_idx CfgLimit  = 3'd4;

    // forward progress at or above this is past any budget
    localparam int FwdBits = 14;
    localparam logic [9:0] BudgetScale = 10'd1000;

    typedef struct packed {
        logic        [31:0] time_ms;
        logic signed [15:0] target_wheel0;
        logic signed [15:0] target_wheel1;
        logic signed [15:0] target_wheel2;
        logic signed [15:0] target_wheel3;
        logic signed [31:0] enc_wheel0;
        logic signed [31:0] enc_wheel1;
        logic signed [31:0] enc_wheel2;
        logic signed [31:0] enc_wheel3;
        logic        [3:0]  degraded_wheels;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] drive_wheel0;
        logic signed [15:0] drive_wheel1;
        logic signed [15:0] drive_wheel2;
        logic signed [15:0] drive_wheel3;
    } t_out_item;

    // products and flags one lane hands to the merge
    typedef struct packed {
        logic [23:0] elapsed_peak;
        logic [23:0] mag_drive;
        logic [23:0] fwd_scaled;
        logic [23:0] mag_period;
        logic        fwd_neg;
        logic        fwd_big;
    } t_lane_res;

    function automatic logic [15:0] mag_of(input logic signed [15:0] t);
        logic [15:0] m;
        m = t[15] ? 16'(-t) : 16'(t);
        return m;
    endfunction

    function automatic t_dir dir_of(input logic signed [15:0] t);
        t_dir d;
        if (t[15]) begin
            d = DirNeg;
        end else if (t != 16'sd0) begin
            d = DirPos;
        end else begin
            d = DirZero;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* design/ptdc_lane.sv */
// ----------------------------------------------------------------------------
// ptdc_lane
// One wheel: forms the width and budget comparisons as registered products.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdc_lane (
    input  wire logic              i_clk,
    input  wire logic [15:0]       i_mag,
    input  wire ptdc_pkg::t_dir    i_dir,
    input  wire logic [31:0]       i_cnt,
    input  wire logic [31:0]       i_snap,
    input  wire logic [7:0]        i_elapsed,
    input  wire logic [15:0]       i_peak,
    input  wire logic [7:0]        i_drive_ms,
    input  wire logic [7:0]        i_period_ms,
    output ptdc_pkg::t_lane_res    o_res
);

    logic [31:0]        delta;
    logic signed [32:0] fwd;
    ptdc_pkg::t_lane_res r_res;

    always_comb begin
        delta = i_cnt - i_snap;
        unique case (i_dir)
            ptdc_pkg::DirPos: fwd = {delta[31], delta};
            ptdc_pkg::DirNeg: fwd = 33'sd0 - {delta[31], delta};
            default:          fwd = 33'sd0;
        endcase
    end

    // elapsed >= ceil(a/b) is elapsed*b >= a, so no divider is needed
    always_ff @(posedge i_clk) begin
        r_res.elapsed_peak <= 24'(i_elapsed) * 24'(i_peak);
        r_res.mag_drive    <= 24'(i_mag) * 24'(i_drive_ms);
        r_res.mag_period   <= 24'(i_mag) * 24'(i_period_ms);
        r_res.fwd_scaled   <= 24'(fwd[ptdc_pkg::FwdBits-1:0]) * 24'(ptdc_pkg::BudgetScale);
        r_res.fwd_neg      <= fwd[32];
        r_res.fwd_big      <= !fwd[32] && (|fwd[31:ptdc_pkg::FwdBits]);
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* design/ptdc_merge.sv */
// ----------------------------------------------------------------------------
// ptdc_merge
// Combines the lane comparisons into the done mask and the drive levels.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdc_merge (
    input  wire ptdc_pkg::t_lane_res i_res  [ptdc_pkg::NumWheels],
    input  wire ptdc_pkg::t_dir      i_dir  [ptdc_pkg::NumWheels],
    input  wire logic [ptdc_pkg::NumWheels-1:0] i_mag_nz,
    input  wire logic [ptdc_pkg::NumWheels-1:0] i_done,
    input  wire logic [ptdc_pkg::NumWheels-1:0] i_degraded,
    input  wire logic [14:0]         i_level,
    output logic [ptdc_pkg::NumWheels-1:0] o_done,
    output logic signed [15:0]       o_drive [ptdc_pkg::NumWheels]
);

    logic [ptdc_pkg::NumWheels-1:0] width_hit;
    logic [ptdc_pkg::NumWheels-1:0] budget_hit;

    always_comb begin
        for (int w = 0; w < ptdc_pkg::NumWheels; w++) begin
            width_hit[w]  = i_res[w].elapsed_peak >= i_res[w].mag_drive;
            budget_hit[w] = !i_degraded[w] && (i_res[w].fwd_big ||
                (!i_res[w].fwd_neg && i_res[w].fwd_scaled >= i_res[w].mag_period));
            o_done[w] = i_done[w] | width_hit[w] | budget_hit[w];
            o_drive[w] = 16'sd0;
            if (i_mag_nz[w] && !o_done[w]) begin
                o_drive[w] = (i_dir[w] == ptdc_pkg::DirNeg) ? -$signed({1'b0, i_level})
                                                           : $signed({1'b0, i_level});
            end
        end
    end

endmodule

`default_nettype wire

/* design/pulsed_turn_drive_controller.sv */
// ----------------------------------------------------------------------------
// pulsed_turn_drive_controller
// Pulsed drive of four wheels with coast on direction change.
// ----------------------------------------------------------------------------
//  channel | signals                               | moves
//  in      | i_in_valid  o_in_ready  i_in_data     | one tick item
//  out     | o_out_valid i_out_ready o_out_data    | four drive levels
//  cfg     | i_cfg_valid o_cfg_ready i_cfg_index/data | one register write
//
//  An item passes idle, prepare and output load when cleared or held in
//  a coast/idle window; when the lanes run, multiply and merge follow prepare.
//  The lane multiplier stage and the merge are what set the longer path.
//  One item is in work at a time; a new item is taken once the result is
//  loaded into the output register. Synchronous active-low reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pulsed_turn_drive_controller_defines.svh"

module pulsed_turn_drive_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ptdc_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ptdc_pkg::t_out_item     o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [14:0]        i_cfg_data
);

    localparam int NW = ptdc_pkg::NumWheels;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MUL  = 5'b00100,
        S_MRG  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]  r_period, r_drive, r_coast;
    logic [14:0] r_level, r_limit;

    logic            r_active, n_active;
    logic            r_coasting, n_coasting;
    logic [NW-1:0]   r_done, n_done;
    logic [31:0]     r_ws, n_ws;
    ptdc_pkg::t_dir  r_wdir [NW];
    ptdc_pkg::t_dir  n_wdir [NW];
    logic [31:0]     r_snap [NW];
    logic [31:0]     n_snap [NW];

    ptdc_pkg::t_in_item r_in;
    logic [15:0]     r_mag [NW];
    logic [15:0]     r_peak;
    logic [7:0]      r_elapsed, n_elapsed;
    logic signed [15:0] r_drv [NW];
    logic            r_out_valid;
    ptdc_pkg::t_out_item r_out;

    logic signed [15:0] tgt [NW];
    logic [31:0]     cnt [NW];
    logic [15:0]     mag [NW];
    ptdc_pkg::t_dir  dir [NW];
    logic [15:0]     peak;
    logic            over, changed, run_lanes, clear_all;
    logic [31:0]     elapsed;

    ptdc_pkg::t_lane_res lane_res [NW];
    logic [NW-1:0]   mag_nz;
    logic [NW-1:0]   mrg_done;
    logic signed [15:0] mrg_drive [NW];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        tgt[0] = r_in.target_wheel0; tgt[1] = r_in.target_wheel1;
        tgt[2] = r_in.target_wheel2; tgt[3] = r_in.target_wheel3;
        cnt[0] = r_in.enc_wheel0;    cnt[1] = r_in.enc_wheel1;
        cnt[2] = r_in.enc_wheel2;    cnt[3] = r_in.enc_wheel3;
    end

    // tick preparation: limits, direction changes, window bookkeeping
    always_comb begin
        over = 1'b0;
        peak = 16'd0;
        changed = 1'b0;
        for (int w = 0; w < NW; w++) begin
            mag[w] = ptdc_pkg::mag_of(tgt[w]);
            dir[w] = ptdc_pkg::dir_of(tgt[w]);
            if (mag[w] > {1'b0, r_limit}) over = 1'b1;
            if (mag[w] > peak) peak = mag[w];
            if (r_active && dir[w] != r_wdir[w]) changed = 1'b1;
        end
        clear_all  = over || (peak == 16'd0);
        n_active   = r_active;
        n_coasting = r_coasting;
        n_done     = r_done;
        n_ws       = r_ws;
        n_wdir     = r_wdir;
        n_snap     = r_snap;
        run_lanes  = 1'b0;
        if (!r_active || changed) begin
            if (!r_active || !r_coasting) n_ws = r_in.time_ms;
            n_active   = 1'b1;
            n_coasting = changed;
            n_done     = '0;
            n_wdir     = dir;
            n_snap     = cnt;
        end
        elapsed = r_in.time_ms - n_ws;
        if (n_coasting) begin
            if (elapsed >= 32'(r_coast)) begin
                n_coasting = 1'b0;
                n_ws       = r_in.time_ms;
                elapsed    = 32'd0;
                n_snap     = cnt;
            end
        end
        if (!n_coasting) begin
            if (elapsed >= 32'(r_period)) begin
                n_ws    = r_in.time_ms;
                elapsed = 32'd0;
                n_done  = '0;
                n_snap  = cnt;
            end
            run_lanes = elapsed < 32'(r_drive);
        end
        n_elapsed = elapsed[7:0];
        if (clear_all) begin
            n_active   = 1'b0;
            n_coasting = 1'b0;
            n_done     = '0;
            n_ws       = 32'd0;
            for (int w = 0; w < NW; w++) begin
                n_wdir[w] = ptdc_pkg::DirZero;
                n_snap[w] = 32'd0;
            end
            run_lanes = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_PREP;
            S_PREP: n_state = run_lanes ? S_MUL : S_OUT;
            S_MUL:  n_state = S_MRG;
            S_MRG:  n_state = S_OUT;
            S_OUT:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < NW; g++) begin : g_lane
            ptdc_lane u_lane (
                .i_clk       (i_clk),
                .i_mag       (r_mag[g]),
                .i_dir       (r_wdir[g]),
                .i_cnt       (cnt[g]),
                .i_snap      (r_snap[g]),
                .i_elapsed   (r_elapsed),
                .i_peak      (r_peak),
                .i_drive_ms  (r_drive),
                .i_period_ms (r_period),
                .o_res       (lane_res[g])
            );
            assign mag_nz[g] = (r_mag[g] != 16'd0);
        end
    endgenerate

    ptdc_merge u_merge (
        .i_res      (lane_res),
        .i_dir      (r_wdir),
        .i_mag_nz   (mag_nz),
        .i_done     (r_done),
        .i_degraded (r_in.degraded_wheels),
        .i_level    (r_level),
        .o_done     (mrg_done),
        .o_drive    (mrg_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= 8'd40;
            r_drive     <= 8'd24;
            r_coast     <= 8'd16;
            r_level     <= 15'd3300;
            r_limit     <= 15'd9000;
            r_active    <= 1'b0;
            r_coasting  <= 1'b0;
            r_done      <= '0;
            r_ws        <= 32'd0;
            r_out_valid <= 1'b0;
            for (int w = 0; w < NW; w++) begin
                r_wdir[w] <= ptdc_pkg::DirZero;
                r_snap[w] <= 32'd0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ptdc_pkg::CfgPeriod: r_period <= i_cfg_data[7:0];
                    ptdc_pkg::CfgDrive:  r_drive  <= i_cfg_data[7:0];
                    ptdc_pkg::CfgCoast:  r_coast  <= i_cfg_data[7:0];
                    ptdc_pkg::CfgLevel:  r_level  <= i_cfg_data;
                    ptdc_pkg::CfgLimit:  r_limit  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_PREP) begin
                r_active   <= n_active;
                r_coasting <= n_coasting;
                r_done     <= n_done;
                r_ws       <= n_ws;
                r_wdir     <= n_wdir;
                r_snap     <= n_snap;
            end
            if (r_state == S_MRG) r_done <= mrg_done;
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_in <= i_in_data;
        if (r_state == S_PREP) begin
            r_mag     <= mag;
            r_peak    <= peak;
            r_elapsed <= n_elapsed;
            for (int w = 0; w < NW; w++) r_drv[w] <= 16'sd0;
        end
        if (r_state == S_MRG) r_drv <= mrg_drive;
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out.drive_wheel0 <= r_drv[0];
            r_out.drive_wheel1 <= r_drv[1];
            r_out.drive_wheel2 <= r_drv[2];
            r_out.drive_wheel3 <= r_drv[3];
        end
    end

    `PTDC_ASSERT_NOW(a_coast_needs_active, r_coasting, r_active, "coasting while inactive")
    `PTDC_ASSERT_NOW(a_done_needs_active, r_done != '0, r_active, "done mask while inactive")
    `PTDC_ASSERT_NOW(a_lanes_run_pushing, r_state == S_MUL, r_active && !r_coasting,
        "lanes run outside a push window")
    `PTDC_ASSERT_NEXT(a_accept_to_prep, i_in_valid && o_in_ready, r_state == S_PREP,
        "accepted item not prepared")

endmodule

`default_nettype wire
